@@ hdl/k_way_merge_min_heap_core_assert.svh @@
// ----------------------------------------------------------------------------
// K-way merge min-heap core: assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// Defining ASSERT_OFF turns every macro into an empty one.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_MIN_HEAP_CORE_ASSERT_SVH
`define K_WAY_MERGE_MIN_HEAP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Plain property checked at every rising edge outside reset.
`define KWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("k-way merge core assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define KWM_ASSERT_NEXT(lbl, ante, cons) `KWM_ASSERT(lbl, (ante) |=> (cons))
`else
`define KWM_ASSERT(lbl, prop)
`define KWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// K-way merge min-heap package
// Sizes, word types, codes and key helpers shared by the merge core modules.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // Heap capacity, one entry per list.
  localparam int unsigned NUM_LISTS = 16;
  localparam int unsigned IDX_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned SIZE_W    = $clog2(NUM_LISTS + 1);
  // Wide enough to hold the right child index of the last entry.
  localparam int unsigned CHILD_W   = SIZE_W + 1;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned LIST_W    = 4;
  localparam int unsigned KEY_W     = VALUE_W + LIST_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [CHILD_W-1:0] child_t;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_START   = 2'd1,
    MODE_NEXT    = 2'd2,
    MODE_EXHAUST = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_EMIT      = 2'd0,
    STATUS_FINISHED  = 2'd1,
    STATUS_LOAD_OK   = 2'd2,
    STATUS_LOAD_FULL = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                      mode;
    logic signed [VALUE_W-1:0]  item_value;
    logic        [LIST_W-1:0]   list_number;
  } in_word_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  out_value;
    logic        [LIST_W-1:0]   source_list;
  } out_word_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } kwm_res_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic  idle;
    size_t heap_size;
  } kwm_stat_t;

  // Flipping the sign bit makes unsigned key order equal to signed value order,
  // with the list number breaking ties.
  function automatic key_t make_key(logic signed [VALUE_W-1:0] value,
                                    logic [LIST_W-1:0] list);
    return {~value[VALUE_W-1], value[VALUE_W-2:0], list};
  endfunction

  function automatic logic signed [VALUE_W-1:0] key_value(key_t key);
    return {~key[KEY_W-1], key[KEY_W-2:LIST_W]};
  endfunction

  function automatic logic [LIST_W-1:0] key_list(key_t key);
    return key[LIST_W-1:0];
  endfunction

  // Parent of a heap position; meaningless for the root.
  function automatic idx_t parent_of(idx_t idx);
    return (idx - idx_t'(1)) >> 1;
  endfunction

endpackage

@@ hdl/kwm_heap_ram.sv @@
// ----------------------------------------------------------------------------
// K-way merge heap store
// Heap entry memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module kwm_heap_ram (
  input  logic           clk_i,
  input  logic           we_i,
  input  kwm_pkg::idx_t  waddr_i,
  input  kwm_pkg::key_t  wdata_i,
  input  kwm_pkg::idx_t  raddr0_i,
  input  kwm_pkg::idx_t  raddr1_i,
  output kwm_pkg::key_t  rdata0_o,
  output kwm_pkg::key_t  rdata1_o
);

  kwm_pkg::key_t mem [kwm_pkg::NUM_LISTS];
  kwm_pkg::key_t rdata0_q;
  kwm_pkg::key_t rdata1_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem[raddr0_i];
    rdata1_q <= mem[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ hdl/kwm_heap_ctrl.sv @@
// ----------------------------------------------------------------------------
// K-way merge heap sequencer
// Takes one input word at a time, reads the heap store, sifts entries up or
// down one level per cycle and hands a single result to the output stage.
// ----------------------------------------------------------------------------
module kwm_heap_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  kwm_pkg::in_word_t   in_word_i,
  input  logic                res_ready_i,
  output kwm_pkg::kwm_res_t   res_o,
  output kwm_pkg::kwm_stat_t  stat_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_DOWN  = 5'b00100,
    S_UP    = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                              state_q, state_d;
  kwm_pkg::in_word_t                   in_q;
  kwm_pkg::key_t                       key_q, key_d;
  kwm_pkg::idx_t                       idx_q, idx_d;
  kwm_pkg::size_t                      size_q, size_d;
  logic [kwm_pkg::LIST_W-1:0]          last_q, last_d;
  kwm_pkg::out_word_t                  res_q, res_d;

  logic                                accept;
  logic                                we;
  kwm_pkg::idx_t                       waddr;
  kwm_pkg::key_t                       wdata;
  kwm_pkg::idx_t                       raddr0, raddr1;
  kwm_pkg::key_t                       rdata0, rdata1;

  kwm_pkg::key_t                       load_key, next_key;
  kwm_pkg::child_t                     child_l, child_r, child_m;
  kwm_pkg::child_t                     grand_l, grand_r;
  logic                                l_ok, r_ok, moved;
  kwm_pkg::key_t                       best_key;

  assign accept = in_valid_i && (state_q == S_IDLE);

  kwm_heap_ram u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // Keys built from the captured word.
  assign load_key = kwm_pkg::make_key(in_q.item_value, in_q.list_number);
  assign next_key = kwm_pkg::make_key(in_q.item_value, last_q);

  // Smallest of the moving key and the valid children of the hole.
  always_comb begin
    child_l  = (kwm_pkg::child_t'(idx_q) << 1) + kwm_pkg::child_t'(1);
    child_r  = child_l + kwm_pkg::child_t'(1);
    l_ok     = child_l < kwm_pkg::child_t'(size_q);
    r_ok     = child_r < kwm_pkg::child_t'(size_q);
    moved    = 1'b0;
    child_m  = child_l;
    best_key = key_q;
    if (l_ok && (rdata0 < best_key)) begin
      moved    = 1'b1;
      child_m  = child_l;
      best_key = rdata0;
    end
    if (r_ok && (rdata1 < best_key)) begin
      moved    = 1'b1;
      child_m  = child_r;
      best_key = rdata1;
    end
    grand_l = (child_m << 1) + kwm_pkg::child_t'(1);
    grand_r = grand_l + kwm_pkg::child_t'(1);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    idx_d   = idx_q;
    size_d  = size_q;
    last_d  = last_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = key_q;
    // While idle the store keeps presenting the root and the last entry.
    raddr0  = '0;
    raddr1  = kwm_pkg::idx_t'(size_q - kwm_pkg::size_t'(1));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        res_d.out_value   = '0;
        res_d.source_list = '0;
        case (in_q.mode)
          kwm_pkg::MODE_LOAD: begin
            if (size_q == kwm_pkg::size_t'(kwm_pkg::NUM_LISTS)) begin
              res_d.status = kwm_pkg::STATUS_LOAD_FULL;
              state_d      = S_DONE;
            end else begin
              res_d.status = kwm_pkg::STATUS_LOAD_OK;
              key_d        = load_key;
              idx_d        = size_q[kwm_pkg::IDX_W-1:0];
              size_d       = size_q + kwm_pkg::size_t'(1);
              raddr0       = kwm_pkg::parent_of(size_q[kwm_pkg::IDX_W-1:0]);
              state_d      = S_UP;
            end
          end

          kwm_pkg::MODE_NEXT: begin
            res_d.status = kwm_pkg::STATUS_EMIT;
            if ((size_q == '0) || (next_key <= rdata0)) begin
              // The new element is the smallest: pass it straight through.
              res_d.out_value   = kwm_pkg::key_value(next_key);
              res_d.source_list = kwm_pkg::key_list(next_key);
              last_d            = kwm_pkg::key_list(next_key);
              state_d           = S_DONE;
            end else begin
              // Replace the root and sift the new element down.
              res_d.out_value   = kwm_pkg::key_value(rdata0);
              res_d.source_list = kwm_pkg::key_list(rdata0);
              last_d            = kwm_pkg::key_list(rdata0);
              key_d             = next_key;
              idx_d             = '0;
              raddr0            = kwm_pkg::idx_t'(1);
              raddr1            = kwm_pkg::idx_t'(2);
              state_d           = S_DOWN;
            end
          end

          default: begin
            if (size_q == '0) begin
              res_d.status = kwm_pkg::STATUS_FINISHED;
              state_d      = S_DONE;
            end else begin
              // Pop: the last entry moves to the root and sifts down.
              res_d.status      = kwm_pkg::STATUS_EMIT;
              res_d.out_value   = kwm_pkg::key_value(rdata0);
              res_d.source_list = kwm_pkg::key_list(rdata0);
              last_d            = kwm_pkg::key_list(rdata0);
              key_d             = rdata1;
              size_d            = size_q - kwm_pkg::size_t'(1);
              idx_d             = '0;
              raddr0            = kwm_pkg::idx_t'(1);
              raddr1            = kwm_pkg::idx_t'(2);
              state_d           = S_DOWN;
            end
          end
        endcase
      end

      S_DOWN: begin
        we = 1'b1;
        if (moved) begin
          // The smaller child moves up into the hole.
          wdata  = best_key;
          idx_d  = child_m[kwm_pkg::IDX_W-1:0];
          raddr0 = grand_l[kwm_pkg::IDX_W-1:0];
          raddr1 = grand_r[kwm_pkg::IDX_W-1:0];
        end else begin
          wdata   = key_q;
          state_d = S_DONE;
        end
      end

      S_UP: begin
        we = 1'b1;
        if ((idx_q == '0) || (rdata0 <= key_q)) begin
          wdata   = key_q;
          state_d = S_DONE;
        end else begin
          // The parent moves down into the hole.
          wdata  = rdata0;
          idx_d  = kwm_pkg::parent_of(idx_q);
          raddr0 = kwm_pkg::parent_of(kwm_pkg::parent_of(idx_q));
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q  <= '0;
      last_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    key_q <= key_d;
    res_q <= res_d;
  end

  assign res_o.valid     = (state_q == S_DONE);
  assign res_o.word      = res_q;
  assign stat_o.idle     = (state_q == S_IDLE);
  assign stat_o.heap_size = size_q;

endmodule

@@ hdl/k_way_merge_min_heap_core.sv @@
// ----------------------------------------------------------------------------
// K-way merge min-heap core
// Merges sorted lists through a min-heap of (value, list number) entries and
// returns one result word for every input word.
// ----------------------------------------------------------------------------
// An input word is taken only while the core is idle. A word that leaves the
// heap store unchanged (a rejected load, an element passed straight through
// or a merge finished) passes from idle through the fetch and done states.
// Every other word also passes through the sift loop, which moves the entry
// one heap level at a time. The sift-down loop reads both children of the
// current position from the two read ports of the heap store and writes one
// entry back in the same cycle. A finished result sits in an output register,
// so the next input word is taken while the result waits.
`include "k_way_merge_min_heap_core_assert.svh"

module k_way_merge_min_heap_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kwm_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kwm_pkg::out_word_t  out_word_o
);

  kwm_pkg::kwm_res_t   res;
  kwm_pkg::kwm_stat_t  stat;
  logic                res_ready;
  logic                out_valid_q;
  kwm_pkg::out_word_t  out_word_q;

  kwm_heap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .stat_o      (stat)
  );

  assign in_stall_o = !stat.idle;

  // Output register: free when empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The heap never holds more entries than it has room for.
  `KWM_ASSERT(a_size_bound, stat.heap_size <= kwm_pkg::size_t'(kwm_pkg::NUM_LISTS))
  // A taken word keeps the core busy in the following cycle.
  `KWM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // Only an emitted element carries a value and a source list.
  `KWM_ASSERT(a_quiet_fields, (out_valid_o && (out_word_o.status != kwm_pkg::STATUS_EMIT)) |-> ((out_word_o.out_value == '0) && (out_word_o.source_list == '0)))

endmodule
